// ===== rtl/core/mdp_pkg.sv =====
// ----------------------------------------------------------------------------
// Mosaic descriptor parser package
// Record kinds, the result record layout and the queue push bundle that the
// parser core hands to its output queue.
// ----------------------------------------------------------------------------
package mdp_pkg;

  // Record kinds carried on the output tuser field.
  typedef enum logic [2:0] {
    KIND_HEADER   = 3'd0,
    KIND_ELEMENT  = 3'd1,
    KIND_CELL     = 3'd2,
    KIND_DONE     = 3'd3,
    KIND_TAG_ERR  = 3'd4,
    KIND_SIZE_ERR = 3'd5,
    KIND_TRUNC    = 3'd6
  } kind_t;

  // Payload fields, declared from the highest bit down so that the last
  // field, entry_point, lands in bit 0 when the struct is placed on tdata.
  typedef struct packed {
    logic [15:0] evt_id;
    logic [15:0] svc_id;
    logic [15:0] stream_id;
    logic [15:0] link_or_length;
    logic [7:0]  linkage_info;
    logic [5:0]  elementary_cell_id;
    logic [2:0]  presentation_info;
    logic [5:0]  lcell_id;
    logic [2:0]  vertical_cells;
    logic [2:0]  horizontal_cells;
    logic        entry_point;
  } payload_t;

  localparam int unsigned PayloadWidth = $bits(payload_t);
  localparam int unsigned TdataWidth   = ((PayloadWidth + 7) / 8) * 8;

  typedef struct packed {
    kind_t    kind;
    payload_t data;
  } rec_t;

  // One input byte produces up to two records; r0 is always the first.
  typedef struct packed {
    logic [1:0] count;
    rec_t       r0;
    rec_t       r1;
  } push_t;

  // Output queue depth; a byte is taken only while two slots are free.
  localparam int unsigned QueueDepth = 4;

endpackage

// ===== rtl/core/mdp_rec_queue.sv =====
// ----------------------------------------------------------------------------
// Mosaic descriptor parser record queue
// Small flip-flop queue that takes zero, one or two records per cycle and
// presents one record per cycle on the output stream while it is ready.
// ----------------------------------------------------------------------------
module mdp_rec_queue (
  input  logic          clk,
  input  logic          rst,
  input  mdp_pkg::push_t push,
  output logic          room,
  output logic          out_valid,
  input  logic          out_ready,
  output mdp_pkg::rec_t out_rec
);
  import mdp_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  rec_t            slots [QueueDepth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic [PtrW-1:0] wr_ptr_1;
  logic            pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != '0);
  assign out_rec   = slots[rd_ptr];
  assign room      = (count <= CntW'(QueueDepth - 2));
  assign wr_ptr_1  = wr_ptr + PtrW'(1);

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      slots[wr_ptr] <= push.r0;
    end
    if (push.count == 2'd2) begin
      slots[wr_ptr_1] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PtrW'(push.count);
      if (pop) begin
        rd_ptr <= rd_ptr + PtrW'(1);
      end
      count <= count + CntW'(push.count) - CntW'(pop);
    end
  end

endmodule

// ===== rtl/core/mosaic_descriptor_parser.sv =====
// ----------------------------------------------------------------------------
// Mosaic descriptor parser
// Byte-serial parser for the mosaic descriptor (tag 0x51) that emits typed
// records for the header, elementary cell ids, cells, completion and errors.
// ----------------------------------------------------------------------------
// Usage:
// Descriptor bytes enter on the s_axis channel, one byte per item, with
// s_axis_tlast marking the last byte available in the buffer. Records leave
// on the m_axis channel: tuser holds the record kind and tdata the fields.
// Each accepted byte is decoded in the cycle it is accepted, against the
// parser state registers, and its zero, one or two records are written into
// a four-entry output queue. A record is therefore held in a queue slot
// register before it reaches m_axis, behind any records still waiting there.
// Throughput is one byte per cycle while s_axis_tready is high, which it is
// while the queue has two free entries, so the block keeps taking bytes while
// earlier records still wait. If the receiver stalls, records collect in the
// queue and tready drops as soon as more than two of them wait; nothing is
// lost or repeated. A byte that makes two records needs an output transfer for
// each, so a long run of such bytes is paced by the receiver.
// Reset (rst, synchronous) empties the queue and returns the parser to
// waiting for a tag byte with all counters and cell registers cleared.
// ----------------------------------------------------------------------------
module mosaic_descriptor_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // buffer_last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [mdp_pkg::TdataWidth-1:0] m_axis_tdata,
  // [0] entry_point, [3:1] horizontal_cells, [6:4] vertical_cells,
  // [12:7] lcell_id, [15:13] presentation_info,
  // [21:16] elementary_cell_id, [29:22] linkage_info,
  // [45:30] link_or_length, [61:46] stream_id, [77:62] svc_id,
  // [93:78] evt_id, upper bits zero
  output logic [2:0]  m_axis_tuser    // [2:0] record_kind
);
  import mdp_pkg::*;

  localparam logic [7:0] DescTag = 8'h51;

  // Linkage codes that carry data bytes after the linkage byte.
  localparam logic [7:0] LinkBouquet  = 8'h01;
  localparam logic [7:0] LinkService  = 8'h02;
  localparam logic [7:0] LinkMosaic   = 8'h03;
  localparam logic [7:0] LinkEvent    = 8'h04;

  typedef enum logic [8:0] {
    PH_TAG   = 9'b000000001,
    PH_LEN   = 9'b000000010,
    PH_HEAD  = 9'b000000100,
    PH_CID   = 9'b000001000,
    PH_PRES  = 9'b000010000,
    PH_ECLEN = 9'b000100000,
    PH_ELEM  = 9'b001000000,
    PH_LINK  = 9'b010000000,
    PH_LDATA = 9'b100000000
  } phase_t;

  typedef logic [15:0] words_t [4];

  // Number of data bytes that follow a linkage byte.
  function automatic logic [3:0] link_len(input logic [7:0] lk);
    logic [3:0] n;
    n = 4'd0;
    if (lk == LinkBouquet) begin
      n = 4'd2;
    end else if (lk == LinkService || lk == LinkMosaic) begin
      n = 4'd6;
    end else if (lk == LinkEvent) begin
      n = 4'd8;
    end
    return n;
  endfunction

  // A cell record built from the cell registers as they stand after this byte.
  // Only a completed cell carries the linkage ids.
  function automatic rec_t cell_rec(input kind_t k, input logic [5:0] cid,
                                    input logic [2:0] pres, input logic [7:0] lk,
                                    input words_t w);
    rec_t r;
    r                        = '0;
    r.kind                   = k;
    r.data.lcell_id          = cid;
    r.data.presentation_info = pres;
    r.data.linkage_info      = lk;
    if (k == KIND_CELL) begin
      r.data.link_or_length = w[0];
      r.data.stream_id      = w[1];
      r.data.svc_id         = w[2];
      r.data.evt_id         = w[3];
    end
    return r;
  endfunction

  phase_t      phase, phase_next;
  logic [7:0]  desc_remaining, desc_remaining_next;
  logic [7:0]  desc_total, desc_total_next;
  logic [7:0]  element_remaining, element_remaining_next;
  logic [2:0]  link_byte_index, link_byte_index_next;
  logic [5:0]  cell_id, cell_id_next;
  logic [2:0]  presentation, presentation_next;
  logic [7:0]  linkage, linkage_next;
  words_t      link_words, link_words_next;
  logic        skip_to_end, skip_to_end_next;

  logic        accept;
  logic [7:0]  b;
  logic        last;
  logic [7:0]  rem_dec;
  logic [7:0]  elem_dec;
  logic [1:0]  word_sel;
  rec_t        rec_a, rec_b;
  logic        a_valid, b_valid;
  push_t       push;
  logic        room;
  rec_t        out_rec;

  assign accept = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = room;
  assign b    = s_axis_tdata;
  assign last = s_axis_tlast;
  assign rem_dec  = desc_remaining - 8'd1;
  assign elem_dec = element_remaining - 8'd1;
  assign word_sel = link_byte_index[2:1];

  always_comb begin
    phase_next             = phase;
    desc_remaining_next    = desc_remaining;
    desc_total_next        = desc_total;
    element_remaining_next = element_remaining;
    link_byte_index_next   = link_byte_index;
    cell_id_next           = cell_id;
    presentation_next      = presentation;
    linkage_next           = linkage;
    link_words_next        = link_words;
    skip_to_end_next       = skip_to_end;
    rec_a   = '0;
    rec_b   = '0;
    a_valid = 1'b0;
    b_valid = 1'b0;

    if (accept) begin
      if (skip_to_end) begin
        // Discard bytes up to the end of the buffer after an error.
        if (last) begin
          skip_to_end_next = 1'b0;
          phase_next       = PH_TAG;
        end
      end else begin
        case (phase)
          PH_TAG: begin
            if (last) begin
              b_valid    = 1'b1;
              rec_b.kind = KIND_SIZE_ERR;
            end else if (b != DescTag) begin
              b_valid          = 1'b1;
              rec_b.kind       = KIND_TAG_ERR;
              skip_to_end_next = 1'b1;
            end else begin
              phase_next = PH_LEN;
            end
          end
          PH_LEN: begin
            desc_total_next     = b;
            desc_remaining_next = b;
            if (b == 8'd0) begin
              b_valid          = 1'b1;
              rec_b.kind       = KIND_SIZE_ERR;
              skip_to_end_next = !last;
              phase_next       = PH_TAG;
            end else if (last) begin
              b_valid    = 1'b1;
              rec_b.kind = KIND_SIZE_ERR;
              phase_next = PH_TAG;
            end else begin
              phase_next = PH_HEAD;
            end
          end
          default: begin
            // Every byte after the length counts against the descriptor.
            desc_remaining_next = rem_dec;
            case (phase)
              PH_HEAD: begin
                a_valid                     = 1'b1;
                rec_a.kind                  = KIND_HEADER;
                rec_a.data.entry_point      = b[7];
                rec_a.data.horizontal_cells = b[6:4];
                rec_a.data.vertical_cells   = b[2:0];
                phase_next                  = PH_CID;
              end
              PH_CID: begin
                cell_id_next      = b[7:2];
                presentation_next = 3'd0;
                linkage_next      = 8'd0;
                for (int i = 0; i < 4; i++) begin
                  link_words_next[i] = 16'd0;
                end
                phase_next = PH_PRES;
              end
              PH_PRES: begin
                presentation_next = b[2:0];
                phase_next        = PH_ECLEN;
              end
              PH_ECLEN: begin
                element_remaining_next = b;
                phase_next             = (b != 8'd0) ? PH_ELEM : PH_LINK;
              end
              PH_ELEM: begin
                a_valid                       = 1'b1;
                rec_a.kind                    = KIND_ELEMENT;
                rec_a.data.lcell_id           = cell_id;
                rec_a.data.presentation_info  = presentation;
                rec_a.data.elementary_cell_id = b[5:0];
                element_remaining_next        = elem_dec;
                if (elem_dec == 8'd0) begin
                  phase_next = PH_LINK;
                end
              end
              PH_LINK: begin
                linkage_next         = b;
                link_byte_index_next = 3'd0;
                for (int i = 0; i < 4; i++) begin
                  link_words_next[i] = 16'd0;
                end
                if (link_len(b) == 4'd0) begin
                  a_valid    = 1'b1;
                  rec_a      = cell_rec(KIND_CELL, cell_id_next, presentation_next,
                                        linkage_next, link_words_next);
                  phase_next = PH_CID;
                end else begin
                  phase_next = PH_LDATA;
                end
              end
              default: begin
                // Linkage data: big-endian 16-bit words, high byte first.
                if (!link_byte_index[0]) begin
                  link_words_next[word_sel] = {b, 8'd0};
                end else begin
                  link_words_next[word_sel] = {link_words[word_sel][15:8], b};
                end
                link_byte_index_next = link_byte_index + 3'd1;
                if ({1'b0, link_byte_index} + 4'd1 >= link_len(linkage)) begin
                  a_valid              = 1'b1;
                  rec_a                = cell_rec(KIND_CELL, cell_id_next,
                                                  presentation_next, linkage_next,
                                                  link_words_next);
                  link_byte_index_next = 3'd0;
                  phase_next           = PH_CID;
                end
              end
            endcase

            // End of descriptor or end of buffer closes the item.
            if (rem_dec == 8'd0) begin
              b_valid = 1'b1;
              if (phase_next == PH_CID) begin
                rec_b.kind                = KIND_DONE;
                rec_b.data.link_or_length = {8'd0, desc_total} + 16'd2;
              end else begin
                rec_b = cell_rec(KIND_TRUNC, cell_id_next, presentation_next,
                                 linkage_next, link_words_next);
              end
              phase_next = PH_TAG;
            end else if (last) begin
              b_valid    = 1'b1;
              rec_b.kind = KIND_SIZE_ERR;
              phase_next = PH_TAG;
            end
          end
        endcase
      end
    end
  end

  // Pack the records so the first one produced always goes out first.
  always_comb begin
    push = '0;
    if (a_valid) begin
      push.r0    = rec_a;
      push.r1    = rec_b;
      push.count = b_valid ? 2'd2 : 2'd1;
    end else begin
      push.r0    = rec_b;
      push.count = {1'b0, b_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_TAG;
      desc_remaining    <= 8'd0;
      desc_total        <= 8'd0;
      element_remaining <= 8'd0;
      link_byte_index   <= 3'd0;
      cell_id           <= 6'd0;
      presentation      <= 3'd0;
      linkage           <= 8'd0;
      skip_to_end       <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        link_words[i] <= 16'd0;
      end
    end else begin
      phase             <= phase_next;
      desc_remaining    <= desc_remaining_next;
      desc_total        <= desc_total_next;
      element_remaining <= element_remaining_next;
      link_byte_index   <= link_byte_index_next;
      cell_id           <= cell_id_next;
      presentation      <= presentation_next;
      linkage           <= linkage_next;
      skip_to_end       <= skip_to_end_next;
      link_words        <= link_words_next;
    end
  end

  mdp_rec_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_rec   (out_rec)
  );

  assign m_axis_tdata = {(TdataWidth - PayloadWidth)'(0), out_rec.data};
  assign m_axis_tuser = out_rec.kind;

endmodule
